>>> design/iterator_index_remap_table_top_assert.svh
// Assertion macros for the iterator index remap table.
`ifndef ITERATOR_INDEX_REMAP_TABLE_TOP_ASSERT_SVH
`define ITERATOR_INDEX_REMAP_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define IRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IRT_ASSERT(lbl, prop, msg) \
    `IRT_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define IRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define IRT_ASSERT(lbl, prop, msg)
`endif

`endif

>>> design/irt_pkg.sv
// Shared types and constants for the iterator index remap table.
package irt_pkg;

    localparam int CNT_W          = 11;
    localparam int DELTA_W        = 12;
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int INDEX_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        KIND_NEXT    = 2'd0,
        KIND_CURRENT = 2'd1,
        KIND_SET_POS = 2'd2,
        KIND_ADJUST  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_END         = 2'd1,
        ST_REMOVED     = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } t_status;

endpackage

>>> design/iterator_index_remap_table_top.sv
// Top level of the iterator index remap table: cursor, order table and sequencer.
//
// Snapshot iterator. Raise start for one cycle while busy is low to hand in a word;
// exactly one result follows, shown for a single cycle with o_strobe high, and the
// receiver cannot stall it. Next and current read the order table when the cursor
// is in range and the table is in use, and answer without it otherwise; set position
// never reads it. Adjust sweeps the order table once through its one read port and
// its one write port, one entry per cycle, and answers without a sweep when the entry
// count is zero. Write entry_count only while the block is idle.
`include "iterator_index_remap_table_top_assert.svh"

module iterator_index_remap_table_top
    import irt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CNT_W-1:0]      i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [CNT_W-1:0]      i_new_position,
    input  logic [INDEX_BITS-1:0] i_change_index,
    input  logic signed [DELTA_W-1:0] i_delta,
    output logic                  o_strobe,
    output logic [INDEX_BITS-1:0] o_entry_index,
    output logic [1:0]            o_status,
    output logic [CNT_W-1:0]      o_cursor
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int DEPTH   = (MAX_ENTRIES < CNT_MAX) ? MAX_ENTRIES : CNT_MAX;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW      = INDEX_BITS + 1;
    localparam int SW      = ((INDEX_BITS > DELTA_W) ? INDEX_BITS : DELTA_W) + 1;
    localparam logic [16:0] MAX_W = 17'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    t_status               r_status;
    logic                  r_strobe;
    logic [INDEX_BITS-1:0] r_index;
    logic [CNT_W-1:0]      r_cursor;
    logic [CNT_W-1:0]      r_count;
    logic                  r_present;
    logic [INDEX_BITS-1:0] r_at;
    logic [DELTA_W-1:0]    r_delta;
    logic [CNT_W-1:0]      r_sweep_idx;
    logic                  r_wb_valid;
    logic [CNT_W-1:0]      r_wb_idx;

    logic [CNT_W-1:0]      live_n;
    logic                  accept;
    logic                  in_range;
    logic                  issue;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [VW-1:0]         rd_data;
    logic                  wr_en;
    logic [VW-1:0]         wr_data;
    logic [VW-1:0]         wb_src;
    logic [CNT_W-1:0]      n_cursor;

    function automatic logic [VW-1:0] f_adjust(
        input logic [VW-1:0]         v,
        input logic [INDEX_BITS-1:0] at,
        input logic [DELTA_W-1:0]    delta
    );
        logic [DELTA_W-1:0] mag;
        logic [SW-1:0]      val;
        logic [SW-1:0]      at_w;
        logic [SW-1:0]      amt;
        logic [SW-1:0]      sum;
        logic [SW-1:0]      top;
        logic [VW-1:0]      res;
        mag  = delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
        val  = SW'(v[INDEX_BITS-1:0]);
        at_w = SW'(at);
        amt  = SW'(mag);
        top  = SW'({INDEX_BITS{1'b1}});
        res  = v;
        if (!v[INDEX_BITS] && val >= at_w) begin
            if (!delta[DELTA_W-1] && delta != '0) begin
                sum = val + amt;
                res = {1'b0, (sum > top) ? top[INDEX_BITS-1:0] : sum[INDEX_BITS-1:0]};
            end else begin
                sum = at_w + amt;
                if (val >= sum) begin
                    res = VW'(val - amt);
                end else begin
                    res = {1'b1, {INDEX_BITS{1'b0}}};
                end
            end
        end
        return res;
    endfunction

    assign live_n   = ({6'd0, r_count} > MAX_W) ? CNT_W'(MAX_ENTRIES) : r_count;
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (r_cursor < live_n);
    assign issue    = (r_sweep_idx < live_n);
    assign n_cursor = r_cursor + 1'b1;

    assign rd_en   = (accept && in_range && r_present &&
                      (t_kind'(i_kind) == KIND_NEXT || t_kind'(i_kind) == KIND_CURRENT)) ||
                     (r_state == S_SWEEP && issue);
    assign rd_addr = (r_state == S_SWEEP) ? r_sweep_idx[AW-1:0] : r_cursor[AW-1:0];
    assign wr_en   = (r_state == S_SWEEP) && r_wb_valid;
    assign wb_src  = r_present ? rd_data : {1'b0, (INDEX_BITS)'(r_wb_idx)};
    assign wr_data = f_adjust(wb_src, r_at, r_delta);

    irt_table_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (VW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wb_idx[AW-1:0]),
        .i_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= KIND_NEXT;
            r_status    <= ST_OK;
            r_strobe    <= 1'b0;
            r_index     <= '0;
            r_cursor    <= '0;
            r_count     <= '0;
            r_present   <= 1'b0;
            r_sweep_idx <= '0;
            r_wb_valid  <= 1'b0;
            r_wb_idx    <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind  <= t_kind'(i_kind);
                        r_at    <= i_change_index;
                        r_delta <= i_delta;
                        r_index <= '0;
                        unique case (t_kind'(i_kind))
                            KIND_NEXT, KIND_CURRENT: begin
                                if (!in_range) begin
                                    r_status <= ST_END;
                                    r_strobe <= 1'b1;
                                end else if (r_present) begin
                                    r_state <= S_LOOK;
                                end else if (t_kind'(i_kind) == KIND_NEXT) begin
                                    r_index  <= (INDEX_BITS)'(r_cursor);
                                    r_cursor <= n_cursor;
                                    r_status <= ST_OK;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_status <= ST_UNSUPPORTED;
                                    r_strobe <= 1'b1;
                                end
                            end
                            KIND_SET_POS: begin
                                r_cursor <= (i_new_position < live_n) ? i_new_position : live_n;
                                r_status <= ST_OK;
                                r_strobe <= 1'b1;
                            end
                            KIND_ADJUST: begin
                                if (live_n == '0) begin
                                    r_status <= ST_OK;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_sweep_idx <= '0;
                                    r_wb_valid  <= 1'b0;
                                    r_state     <= S_SWEEP;
                                end
                            end
                        endcase
                    end
                end
                S_LOOK: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    if (r_kind == KIND_NEXT) begin
                        r_cursor <= n_cursor;
                        if (rd_data[INDEX_BITS]) begin
                            r_status <= ST_REMOVED;
                        end else begin
                            r_status <= ST_OK;
                            r_index  <= rd_data[INDEX_BITS-1:0];
                        end
                    end else begin
                        r_status <= rd_data[INDEX_BITS] ? ST_REMOVED : ST_UNSUPPORTED;
                    end
                end
                S_SWEEP: begin
                    r_wb_valid <= issue;
                    r_wb_idx   <= r_sweep_idx;
                    if (issue) begin
                        r_sweep_idx <= r_sweep_idx + 1'b1;
                    end else if (!r_wb_valid) begin
                        r_present <= 1'b1;
                        r_status  <= ST_OK;
                        r_strobe  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_entry_index = r_index;
    assign o_status      = r_status;
    assign o_cursor      = r_cursor;

    `IRT_ASSERT(a_strobe_has_cause, o_strobe |-> $past(r_state != S_IDLE || accept), "result without a word in work")
    `IRT_ASSERT(a_strobe_when_idle, o_strobe |-> r_state == S_IDLE, "result shown while still busy")
    `IRT_ASSERT(a_set_clamped, (o_strobe && r_kind == KIND_SET_POS) |-> r_cursor <= live_n, "set position not clamped")
    `IRT_ASSERT(a_present_from_sweep, $rose(r_present) |-> $past(r_state == S_SWEEP), "table marked present without a sweep")
    `IRT_ASSERT(a_write_in_range, wr_en |-> r_wb_idx < live_n, "table write past entry count")

endmodule

>>> design/irt_table_ram.sv
// Order table memory: one write port, one registered read port.
module irt_table_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 17
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
